@@ rtl/core/lsfg_pkg.sv @@
// lsfg_pkg: constants, codes and controller/datapath signal groups for the led strip
// frame generator; used by every module of the block
package lsfg_pkg;

  localparam int unsigned NUM_LEDS   = 12;
  localparam int unsigned EDGE_BYTES = 4;
  localparam int unsigned FRAME_LEN  = EDGE_BYTES + 4 * NUM_LEDS + EDGE_BYTES;
  localparam int unsigned POS_W      = $clog2(FRAME_LEN);
  localparam int unsigned LED_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  localparam logic [7:0] HDR_START  = 8'b1110_0000;
  localparam logic [7:0] HDR_BRIGHT = 8'b0001_1111;
  localparam logic [7:0] BLUE_RESET = 8'hFF;

  typedef enum logic [1:0] {
    OP_SET      = 2'd0,
    OP_SET_SEND = 2'd1,
    OP_SEND     = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic store_we;
    logic load_ack;
    logic ack_err;
    logic load_frame;
  } lsfg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic idx_ok;
    logic pos_last;
  } lsfg_sts_t;

endpackage

@@ rtl/core/lsfg_cmd_if.sv @@
// lsfg_cmd_if: input channel of the frame generator, valid/ready plus command fields
// depends on nothing
interface lsfg_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output opcode, output led_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input opcode, input led_index, input red,
                  input green, input blue, output ready);
endinterface

@@ rtl/core/lsfg_res_if.sv @@
// lsfg_res_if: result channel of the frame generator, valid/ready plus result fields
// depends on nothing
interface lsfg_res_if;
  logic       valid;
  logic       ready;
  logic       is_frame_byte;
  logic [7:0] byte_out;
  logic       index_error;
  logic       last;

  modport source (output valid, output is_frame_byte, output byte_out,
                  output index_error, output last, input ready);
  modport sink   (input valid, input is_frame_byte, input byte_out,
                  input index_error, input last, output ready);
endinterface

@@ rtl/core/lsfg_ctrl.sv @@
// lsfg_ctrl: command decode and frame sequencing state machine
// depends on lsfg_pkg
module lsfg_ctrl import lsfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  output logic       in_ready_o,
  input  lsfg_sts_t  sts_i,
  output lsfg_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          case (op_e'(opcode_i))
            OP_SET: begin
              cmd_o.store_we = sts_i.idx_ok;
              cmd_o.load_ack = 1'b1;
              cmd_o.ack_err  = !sts_i.idx_ok;
            end
            OP_SET_SEND: begin
              if (sts_i.idx_ok) begin
                cmd_o.store_we = 1'b1;
                state_d        = ST_SEND;
              end else begin
                cmd_o.load_ack = 1'b1;
                cmd_o.ack_err  = 1'b1;
              end
            end
            OP_SEND: begin
              state_d = ST_SEND;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.load_frame = 1'b1;
          if (sts_i.pos_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/lsfg_datapath.sv @@
// lsfg_datapath: color store, frame position counter, byte select and result register
// depends on lsfg_pkg
module lsfg_datapath import lsfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lsfg_cmd_t  cmd_i,
  output lsfg_sts_t  sts_o,
  input  logic [7:0] led_index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       is_frame_byte_o,
  output logic [7:0] byte_out_o,
  output logic       index_error_o,
  output logic       last_o
);

  color_t            store_q [NUM_LEDS];
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              valid_q, valid_d;
  logic              frame_q, err_q, last_q;
  logic [7:0]        byte_q;

  logic [POS_W-1:0]  off;
  logic [LED_W-1:0]  led_sel;
  logic [LED_W-1:0]  wr_sel;
  color_t            cur;
  logic [7:0]        frame_byte;
  logic              pos_last;

  assign pos_last = (pos_q == POS_W'(FRAME_LEN - 1));
  assign wr_sel   = LED_W'(led_index_i);

  assign sts_o.out_free = !valid_q || out_ready_i;
  assign sts_o.idx_ok   = (led_index_i < 8'(NUM_LEDS));
  assign sts_o.pos_last = pos_last;

  // byte select for the current frame position
  always_comb begin
    off        = pos_q - POS_W'(EDGE_BYTES);
    led_sel    = LED_W'(off >> 2);
    cur        = store_q[led_sel];
    frame_byte = 8'h00;
    if (pos_q >= POS_W'(EDGE_BYTES) && pos_q < POS_W'(EDGE_BYTES + 4 * NUM_LEDS)) begin
      case (off[1:0])
        2'd0:    frame_byte = HDR_START | HDR_BRIGHT;
        2'd1:    frame_byte = cur.blue;
        2'd2:    frame_byte = cur.green;
        default: frame_byte = cur.red;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        store_q[i] <= '{red: 8'h00, green: 8'h00, blue: BLUE_RESET};
      end
    end else if (cmd_i.store_we) begin
      store_q[wr_sel] <= '{red: red_i, green: green_i, blue: blue_i};
    end
  end

  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q;
    if (cmd_i.load_frame) begin
      pos_d = pos_last ? '0 : pos_q + POS_W'(1);
    end
    if (cmd_i.load_frame || cmd_i.load_ack) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      frame_q <= 1'b1;
      byte_q  <= frame_byte;
      err_q   <= 1'b0;
      last_q  <= pos_last;
    end else if (cmd_i.load_ack) begin
      frame_q <= 1'b0;
      byte_q  <= 8'h00;
      err_q   <= cmd_i.ack_err;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o     = valid_q;
  assign is_frame_byte_o = frame_q;
  assign byte_out_o      = byte_q;
  assign index_error_o   = err_q;
  assign last_o          = last_q;

endmodule

@@ rtl/core/led_strip_frame_generator_top.sv @@
// led_strip_frame_generator_top: Set commands give one acknowledge transfer. A send
// command (or a good set then send) gives 4*NUM_LEDS+8 byte transfers, 56 for twelve
// LEDs, one per cycle while the sink takes them; the frame sequencer walks the color
// store one byte per cycle while the sink keeps up; a new command is taken after the
// marked last byte has been loaded into the result register. Colors reset to blue.
// depends on lsfg_pkg, lsfg_cmd_if, lsfg_res_if, lsfg_ctrl, lsfg_datapath
module led_strip_frame_generator_top import lsfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsfg_cmd_if.sink   cmd_i,
  lsfg_res_if.source res_o
);

  lsfg_cmd_t cmd;
  lsfg_sts_t sts;

  lsfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .opcode_i   (cmd_i.opcode),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsfg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .led_index_i     (cmd_i.led_index),
    .red_i           (cmd_i.red),
    .green_i         (cmd_i.green),
    .blue_i          (cmd_i.blue),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .is_frame_byte_o (res_o.is_frame_byte),
    .byte_out_o      (res_o.byte_out),
    .index_error_o   (res_o.index_error),
    .last_o          (res_o.last)
  );

endmodule
